[sv/dnfp_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the decimal number field parser
// no dependencies

package dnfp_pkg;

  localparam int unsigned AccWidthDef = 64;
  localparam int unsigned CharWidth   = 8;
  localparam int unsigned FracWidth   = 6;
  localparam int unsigned ErrWidth    = 3;

  localparam logic [CharWidth-1:0] CharZero  = 8'h30;
  localparam logic [CharWidth-1:0] CharNine  = 8'h39;
  localparam logic [CharWidth-1:0] CharMinus = 8'h2d;
  localparam logic [CharWidth-1:0] CharPoint = 8'h2e;

  localparam logic [FracWidth-1:0] FracMax = {FracWidth{1'b1}};

  typedef enum logic [ErrWidth-1:0] {
    ErrNone       = 3'd0,
    ErrEmpty      = 3'd1,
    ErrBad        = 3'd2,
    ErrLeadPoint  = 3'd3,
    ErrMultiPoint = 3'd4,
    ErrTrailPoint = 3'd5,
    ErrOverflow   = 3'd6
  } error_code_e;

  typedef struct packed {
    logic [CharWidth-1:0] character;
    logic                 end_of_field;
  } item_t;

  typedef struct packed {
    logic [FracWidth-1:0] fraction_digits;
    error_code_e          error_code;
  } res_meta_t;

endpackage

[sv/dnfp_in_reg.sv]
`timescale 1ns / 1ps
// input register stage holding one transaction
// depends on dnfp_pkg

module dnfp_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  dnfp_pkg::item_t item_i,
  output logic           valid_o,
  input  logic           advance_i,
  output dnfp_pkg::item_t item_o
);
  import dnfp_pkg::*;

  logic  valid_q;
  item_t item_q;

  assign ready_o = !valid_q || advance_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

[sv/dnfp_field.sv]
`timescale 1ns / 1ps
// field scan state: sign, accumulator, point tracking and first error
// depends on dnfp_pkg

module dnfp_field #(
  parameter int unsigned AccWidth = dnfp_pkg::AccWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  dnfp_pkg::item_t      item_i,
  input  logic                 number_mode_i,
  output logic [AccWidth-1:0]  mantissa_o,
  output dnfp_pkg::res_meta_t  meta_o
);
  import dnfp_pkg::*;

  localparam int unsigned ProdWidth = AccWidth + 4;
  localparam logic [ProdWidth-1:0] Limit = {5'b0, {(AccWidth-1){1'b1}}};

  logic [AccWidth-1:0]  acc_q, acc_d;
  logic                 neg_q, neg_d;
  logic [1:0]           seen_q, seen_d;
  logic                 point_q, point_d;
  logic                 last_pt_q, last_pt_d;
  logic [FracWidth-1:0] frac_q, frac_d;
  error_code_e          err_q, err_d;
  logic                 das_q, das_d;

  logic [CharWidth-1:0] ch;
  logic [3:0]           digit;
  logic [ProdWidth-1:0] acc_ext;
  logic [ProdWidth-1:0] prod;
  logic                 is_digit;
  logic                 ovf;
  error_code_e          res_err;

  assign ch       = item_i.character;
  assign digit    = ch[3:0];
  assign is_digit = (ch >= CharZero) && (ch <= CharNine);
  assign acc_ext  = {4'b0, acc_q};
  assign prod     = (acc_ext << 3) + (acc_ext << 1) + {{(ProdWidth-4){1'b0}}, digit};
  assign ovf      = prod > Limit;

  always_comb begin
    if (!das_q) begin
      res_err = ErrEmpty;
    end else if (err_q != ErrNone) begin
      res_err = err_q;
    end else if (last_pt_q) begin
      res_err = ErrTrailPoint;
    end else begin
      res_err = ErrNone;
    end
    if (res_err == ErrNone) begin
      mantissa_o             = neg_q ? (~acc_q + 1'b1) : acc_q;
      meta_o.fraction_digits = frac_q;
    end else begin
      mantissa_o             = '0;
      meta_o.fraction_digits = '0;
    end
    meta_o.error_code = res_err;
  end

  always_comb begin
    acc_d     = acc_q;
    neg_d     = neg_q;
    seen_d    = seen_q;
    point_d   = point_q;
    last_pt_d = last_pt_q;
    frac_d    = frac_q;
    err_d     = err_q;
    das_d     = das_q;
    if (item_i.end_of_field) begin
      acc_d     = '0;
      neg_d     = 1'b0;
      seen_d    = '0;
      point_d   = 1'b0;
      last_pt_d = 1'b0;
      frac_d    = '0;
      err_d     = ErrNone;
      das_d     = 1'b0;
    end else begin
      if (seen_q != 2'd2) begin
        seen_d = seen_q + 2'd1;
      end
      if ((seen_q == 2'd0) && (ch == CharMinus)) begin
        neg_d     = 1'b1;
        last_pt_d = 1'b0;
      end else if ((ch == CharPoint) && number_mode_i) begin
        if (err_q == ErrNone) begin
          if (!das_q) begin
            err_d = ErrLeadPoint;
          end else if (point_q) begin
            err_d = ErrMultiPoint;
          end
        end
        point_d   = 1'b1;
        last_pt_d = 1'b1;
        das_d     = 1'b1;
      end else begin
        das_d     = 1'b1;
        last_pt_d = 1'b0;
        if (!is_digit) begin
          if (err_q == ErrNone) begin
            err_d = ErrBad;
          end
        end else if (err_q == ErrNone) begin
          if (ovf || (point_q && (frac_q == FracMax))) begin
            err_d = ErrOverflow;
          end else begin
            if (point_q) begin
              frac_d = frac_q + 1'b1;
            end
            acc_d = prod[AccWidth-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      neg_q     <= 1'b0;
      seen_q    <= '0;
      point_q   <= 1'b0;
      last_pt_q <= 1'b0;
      frac_q    <= '0;
      err_q     <= ErrNone;
      das_q     <= 1'b0;
    end else if (step_i) begin
      acc_q     <= acc_d;
      neg_q     <= neg_d;
      seen_q    <= seen_d;
      point_q   <= point_d;
      last_pt_q <= last_pt_d;
      frac_q    <= frac_d;
      err_q     <= err_d;
      das_q     <= das_d;
    end
  end

endmodule

[sv/dnfp_out_reg.sv]
`timescale 1ns / 1ps
// result register holding one finished field transaction
// depends on dnfp_pkg

module dnfp_out_reg #(
  parameter int unsigned AccWidth = dnfp_pkg::AccWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  logic [AccWidth-1:0] mantissa_i,
  input  dnfp_pkg::res_meta_t meta_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [AccWidth-1:0] mantissa_o,
  output dnfp_pkg::res_meta_t meta_o
);
  import dnfp_pkg::*;

  logic                valid_q;
  logic [AccWidth-1:0] mantissa_q;
  res_meta_t           meta_q;

  assign valid_o    = valid_q;
  assign mantissa_o = mantissa_q;
  assign meta_o     = meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      mantissa_q <= mantissa_i;
      meta_q     <= meta_i;
    end
  end

endmodule

[sv/decimal_number_field_parser_core.sv]
`timescale 1ns / 1ps
// top level of the decimal number field parser
// depends on dnfp_pkg, dnfp_in_reg, dnfp_field, dnfp_out_reg
//
// channel   direction  signals
// in        input      in_valid_i / in_ready_o, character_i, end_of_field_i
// out       output     out_valid_o / out_ready_i, mantissa_o, fraction_digits_o, error_code_o
// cfg       input      cfg_valid_i / cfg_ready_o, cfg_number_mode_i
//
// one transaction per cycle unless a terminator stalls; each result is registered
// the accumulator update (times ten plus digit, overflow compare) sets the cycle
// reset clears the field state and the mode register to integer mode
// character transactions keep flowing while a result waits; only a terminator
// stalls behind an untaken result

module decimal_number_field_parser_core #(
  parameter int unsigned AccWidth = dnfp_pkg::AccWidthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [dnfp_pkg::CharWidth-1:0]    character_i,
  input  logic                              end_of_field_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [AccWidth-1:0]        mantissa_o,
  output logic [dnfp_pkg::FracWidth-1:0]    fraction_digits_o,
  output logic [dnfp_pkg::ErrWidth-1:0]     error_code_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic                              cfg_number_mode_i
);
  import dnfp_pkg::*;

  item_t               in_item;
  item_t               st_item;
  logic                st_valid;
  logic                advance;
  logic                mode_q;
  logic [AccWidth-1:0] res_mantissa;
  res_meta_t           res_meta;
  logic [AccWidth-1:0] out_mantissa;
  res_meta_t           out_meta;

  assign in_item.character    = character_i;
  assign in_item.end_of_field = end_of_field_i;

  assign advance = st_valid && (!st_item.end_of_field || !out_valid_o || out_ready_i);

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_number_mode_i;
    end
  end

  dnfp_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .ready_o   (in_ready_o),
    .item_i    (in_item),
    .valid_o   (st_valid),
    .advance_i (advance),
    .item_o    (st_item)
  );

  dnfp_field #(
    .AccWidth (AccWidth)
  ) u_field (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .item_i        (st_item),
    .number_mode_i (mode_q),
    .mantissa_o    (res_mantissa),
    .meta_o        (res_meta)
  );

  dnfp_out_reg #(
    .AccWidth (AccWidth)
  ) u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance && st_item.end_of_field),
    .mantissa_i (res_mantissa),
    .meta_i     (res_meta),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .mantissa_o (out_mantissa),
    .meta_o     (out_meta)
  );

  assign mantissa_o        = out_mantissa;
  assign fraction_digits_o = out_meta.fraction_digits;
  assign error_code_o      = out_meta.error_code;

endmodule

[tb/sv/dnfp_field_checker.sv]
`timescale 1ns / 1ps
// result checker for decimal_number_field_parser_core: tracks the mode register and
// field state from the input and cfg transactions, predicts every terminator result
// depends on dnfp_pkg

module dnfp_field_checker
  import dnfp_pkg::*;
#(
  parameter int unsigned AccWidth = AccWidthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [CharWidth-1:0]       character_i,
  input  logic                       end_of_field_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic signed [AccWidth-1:0] mantissa_i,
  input  logic [FracWidth-1:0]       fraction_digits_i,
  input  logic [ErrWidth-1:0]        error_code_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic                       cfg_number_mode_i,
  output int unsigned                fail_count_o,
  output int unsigned                pending_o
);

  localparam logic [AccWidth-1:0] AccLimit = {1'b0, {(AccWidth-1){1'b1}}};

  typedef struct {
    logic signed [AccWidth-1:0] mantissa;
    logic [FracWidth-1:0]       fraction_digits;
    error_code_e                error_code;
  } parsed_number_t;

  parsed_number_t expected_numbers[$];

  logic                 mode_real;
  logic [AccWidth-1:0]  magnitude;
  logic                 negative;
  logic [1:0]           chars_seen;
  logic                 point_seen;
  logic                 last_point;
  logic [FracWidth-1:0] frac_count;
  error_code_e          first_err;
  logic                 past_sign;

  function automatic void clear_field();
    magnitude  = '0;
    negative   = 1'b0;
    chars_seen = 2'd0;
    point_seen = 1'b0;
    last_point = 1'b0;
    frac_count = '0;
    first_err  = ErrNone;
    past_sign  = 1'b0;
  endfunction

  function automatic void keep_first_error(input error_code_e code);
    if (first_err == ErrNone) first_err = code;
  endfunction

  function automatic void scan_character(input logic [CharWidth-1:0] c);
    logic                is_first;
    logic [AccWidth-1:0] digit;
    is_first = (chars_seen == 2'd0);
    if (chars_seen < 2'd2) chars_seen = chars_seen + 2'd1;
    if (is_first && c == CharMinus) begin
      negative   = 1'b1;
      last_point = 1'b0;
    end else if (c == CharPoint && mode_real) begin
      if (!past_sign) keep_first_error(ErrLeadPoint);
      else if (point_seen) keep_first_error(ErrMultiPoint);
      point_seen = 1'b1;
      last_point = 1'b1;
      past_sign  = 1'b1;
    end else begin
      past_sign  = 1'b1;
      last_point = 1'b0;
      if (c < CharZero || c > CharNine) begin
        keep_first_error(ErrBad);
      end else if (first_err == ErrNone) begin
        digit = AccWidth'(c - CharZero);
        if (magnitude > (AccLimit - digit) / 10) begin
          keep_first_error(ErrOverflow);
        end else if (point_seen && frac_count == FracMax) begin
          keep_first_error(ErrOverflow);
        end else begin
          if (point_seen) frac_count = frac_count + 1'b1;
          magnitude = magnitude * 10 + digit;
        end
      end
    end
  endfunction

  function automatic void close_field();
    parsed_number_t num;
    if (!past_sign) num.error_code = ErrEmpty;
    else if (first_err != ErrNone) num.error_code = first_err;
    else if (last_point) num.error_code = ErrTrailPoint;
    else num.error_code = ErrNone;
    if (num.error_code == ErrNone) begin
      num.mantissa        = negative ? ({AccWidth{1'b0}} - magnitude) : magnitude;
      num.fraction_digits = frac_count;
    end else begin
      num.mantissa        = '0;
      num.fraction_digits = '0;
    end
    expected_numbers.push_back(num);
    clear_field();
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    parsed_number_t want;
    if (!rst_ni) begin
      mode_real = 1'b0;
      clear_field();
      expected_numbers.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_numbers.size() == 0) begin
          $display("%0t: result with no terminator pending, mantissa %0d error %0d",
                   $time, mantissa_i, error_code_i);
          fail_count_o++;
        end else begin
          want = expected_numbers.pop_front();
          if (mantissa_i !== want.mantissa) begin
            $display("%0t: mantissa mismatch, expected %0d, actual %0d",
                     $time, want.mantissa, mantissa_i);
            fail_count_o++;
          end
          if (fraction_digits_i !== want.fraction_digits) begin
            $display("%0t: fraction_digits mismatch, expected %0d, actual %0d",
                     $time, want.fraction_digits, fraction_digits_i);
            fail_count_o++;
          end
          if (error_code_i !== want.error_code) begin
            $display("%0t: error_code mismatch, expected %0d, actual %0d",
                     $time, want.error_code, error_code_i);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) mode_real = cfg_number_mode_i;
      if (in_valid_i && in_ready_i) begin
        if (end_of_field_i) close_field();
        else scan_character(character_i);
      end
    end
    pending_o = expected_numbers.size();
  end

endmodule

[tb/sv/tb_decimal_number_field_parser_core.sv]
`timescale 1ns / 1ps
// testbench top for decimal_number_field_parser_core: directed and random text fields
// with bursty input, stalling output and mode changes; depends on dnfp_pkg and dnfp_field_checker

module tb_decimal_number_field_parser_core;
  import dnfp_pkg::*;

  localparam int HalfPeriod  = 4;
  localparam int IdleCycles  = 6;
  localparam int RandomItems = 1700;
  localparam int HoldCycles  = 300;

  typedef logic [CharWidth-1:0] text_t[$];

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic [CharWidth-1:0]        character;
  logic                        end_of_field;
  logic                        out_valid;
  logic                        out_ready;
  logic signed [AccWidthDef-1:0] mantissa;
  logic [FracWidth-1:0]        fraction_digits;
  logic [ErrWidth-1:0]         error_code;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic                        cfg_number_mode;
  int unsigned                 fail_count;
  int unsigned                 pending;

  int  items_sent = 0;
  int  burst_left = 0;
  bit  pace_gaps  = 1'b1;
  bit  hold_req   = 1'b0;
  bit  mode_is_real = 1'b0;

  always #(HalfPeriod) clk = ~clk;

  decimal_number_field_parser_core u_top (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .character_i       (character),
    .end_of_field_i    (end_of_field),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .mantissa_o        (mantissa),
    .fraction_digits_o (fraction_digits),
    .error_code_o      (error_code),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_number_mode_i (cfg_number_mode)
  );

  dnfp_field_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .character_i       (character),
    .end_of_field_i    (end_of_field),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .mantissa_i        (mantissa),
    .fraction_digits_i (fraction_digits),
    .error_code_i      (error_code),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_number_mode_i (cfg_number_mode),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  // called at a falling edge, returns at a falling edge
  task automatic offer(input logic [CharWidth-1:0] c, input logic eof);
    if (pace_gaps) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    in_valid     <= 1'b1;
    character    <= c;
    end_of_field <= eof;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_field(input text_t f);
    foreach (f[i]) offer(f[i], 1'b0);
    offer(CharWidth'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic text_t text_of(input string s);
    text_t f;
    for (int i = 0; i < s.len(); i++) f.push_back(s[i]);
    return f;
  endfunction

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (IdleCycles) @(negedge clk);
  endtask

  task automatic write_mode(input logic v);
    cfg_valid       <= 1'b1;
    cfg_number_mode <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid    <= 1'b0;
    mode_is_real = v;
  endtask

  function automatic text_t number_text();
    text_t f;
    int    n;
    if ($urandom_range(0, 2) == 0) f.push_back(CharMinus);
    n = ($urandom_range(0, 14) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 6);
    repeat (n) f.push_back(CharZero + CharWidth'($urandom_range(0, 9)));
    if (mode_is_real && $urandom_range(0, 2) != 0) begin
      f.push_back(CharPoint);
      repeat ($urandom_range(1, 5)) f.push_back(CharZero + CharWidth'($urandom_range(0, 9)));
    end
    return f;
  endfunction

  function automatic text_t random_field();
    text_t                f;
    int                   kind;
    logic [CharWidth-1:0] c;
    kind = $urandom_range(0, 199);
    if (kind < 90) begin
      f = number_text();
    end else if (kind < 106) begin
      // around the largest magnitude
      f = text_of("9223372036854775807");
      if ($urandom_range(0, 1)) f[f.size()-1] = CharZero + 8'd8;
      if ($urandom_range(0, 3) == 0) f.push_back(CharZero + CharWidth'($urandom_range(0, 9)));
      if (mode_is_real && $urandom_range(0, 1)) f.insert($urandom_range(1, f.size()-1), CharPoint);
      if ($urandom_range(0, 1)) f.push_front(CharMinus);
    end else if (kind < 109) begin
      // long zero fraction, around the fraction count limit
      f = {CharZero, CharPoint};
      repeat ($urandom_range(61, 65)) f.push_back(CharZero);
    end else if (kind < 155) begin
      f = number_text();
      case ($urandom_range(0, 2))
        0:       c = CharMinus;
        1:       c = CharPoint;
        default: c = CharWidth'($urandom_range(0, 255));
      endcase
      f.insert($urandom_range(0, f.size()), c);
    end else begin
      repeat ($urandom_range(0, 5)) begin
        case ($urandom_range(0, 3))
          0:       c = CharZero + CharWidth'($urandom_range(0, 9));
          1:       c = $urandom_range(0, 1) ? CharMinus : CharPoint;
          default: c = CharWidth'($urandom_range(0, 255));
        endcase
        f.push_back(c);
      end
    end
    return f;
  endfunction

  // receiver: stall styles in random segments, one long hold on request
  initial begin
    int unsigned rot;
    out_ready = 1'b0;
    rot = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        case ($urandom_range(0, 2))
          0: repeat ($urandom_range(1, 40)) begin
            out_ready <= 1'b1;
            @(negedge clk);
          end
          1: repeat ($urandom_range(1, 40)) begin
            out_ready <= ($urandom_range(0, 2) != 0);
            @(negedge clk);
          end
          default: repeat ($urandom_range(1, 40)) begin
            out_ready <= 1'((5'b10110 >> (rot % 5)) & 5'd1);
            rot++;
            @(negedge clk);
          end
        endcase
      end
    end
  end

  initial begin
    int phase;
    int phase_end;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    character       = '0;
    end_of_field    = 1'b0;
    cfg_valid       = 1'b0;
    cfg_number_mode = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // integer mode after reset
    send_field(text_of(""));
    send_field(text_of("-"));
    send_field(text_of("9-"));
    send_field(text_of("."));
    send_field({8'hff, 8'h00});
    wait_idle();
    write_mode(1'b1);
    send_field(text_of("-.5"));
    send_field(text_of("1.2.3"));
    send_field(text_of("7."));
    // mode switched to integer in the middle of a field
    offer(CharZero + 8'd1, 1'b0);
    wait_idle();
    write_mode(1'b0);
    offer(CharPoint, 1'b0);
    offer(8'h00, 1'b1);

    phase = 0;
    while (items_sent < RandomItems + 27) begin
      wait_idle();
      write_mode(phase[0] ? 1'b0 : 1'b1);
      pace_gaps = (phase % 4 != 3);
      if (phase == 2) begin
        hold_req  = 1'b1;
        pace_gaps = 1'b0;
      end
      phase_end = items_sent + 220;
      while (items_sent < phase_end) send_field(random_field());
      phase++;
    end

    wait_idle();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
